### hw/rtl/simt_divergence_stack_macros.svh
// Assertion macros for the SIMT divergence stack checker.
`ifndef SIMT_DIVERGENCE_STACK_MACROS_SVH
`define SIMT_DIVERGENCE_STACK_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset.
`define SDS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("divergence stack check failed");

// Next-cycle implication, sampled on clk, disabled during reset.
`define SDS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("divergence stack check failed");

`endif

### hw/rtl/sds_pkg.sv
// Shared types and constants of the SIMT divergence stack.
package sds_pkg;

	localparam int CMD_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_LAUNCH = 2'd0,
		CMD_BRANCH = 2'd1,
		CMD_JOIN   = 2'd2
	} sds_cmd_t;

	typedef struct packed {
		logic launch;
		logic push_one;
		logic push_two;
		logic err;
	} sds_ctrl_t;

endpackage

### hw/rtl/sds_ifs.sv
// Input and result channel interfaces of the SIMT divergence stack.
interface sds_in_if #(
	parameter int NUM_WARPS = 4,
	parameter int LANES     = 8,
	parameter int PC_BITS   = 16
) ();
	localparam int WARP_W = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;

	logic                      valid;
	logic                      ready;
	logic [sds_pkg::CMD_W-1:0] cmd;
	logic [WARP_W-1:0]         warp;
	logic [PC_BITS-1:0]        branch_pc;
	logic [PC_BITS-1:0]        target;
	logic [LANES-1:0]          taken_mask;
	logic                      reconv_valid;
	logic [PC_BITS-1:0]        reconv_pc;

	modport source (
		output valid, cmd, warp, branch_pc, target, taken_mask, reconv_valid, reconv_pc,
		input  ready
	);
	modport sink (
		input  valid, cmd, warp, branch_pc, target, taken_mask, reconv_valid, reconv_pc,
		output ready
	);
endinterface

interface sds_out_if #(
	parameter int NUM_WARPS   = 4,
	parameter int LANES       = 8,
	parameter int STACK_DEPTH = 4,
	parameter int PC_BITS     = 16
) ();
	localparam int WARP_W = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);

	logic               valid;
	logic               ready;
	logic [WARP_W-1:0]  warp_out;
	logic [PC_BITS-1:0] next_pc;
	logic [LANES-1:0]   active_mask;
	logic [SP_W-1:0]    stack_depth;
	logic               error;

	modport source (
		output valid, warp_out, next_pc, active_mask, stack_depth, error,
		input  ready
	);
	modport sink (
		input  valid, warp_out, next_pc, active_mask, stack_depth, error,
		output ready
	);
endinterface

### hw/rtl/sds_resolve.sv
// Launch, branch and join resolution for one warp: next pc, mask, depth and stack pushes.
module sds_resolve #(
	parameter int LANES       = 8,
	parameter int STACK_DEPTH = 4,
	parameter int PC_BITS     = 16,
	localparam int SP_W       = $clog2(STACK_DEPTH + 1)
) (
	input  logic [sds_pkg::CMD_W-1:0] cmd,
	input  logic [PC_BITS-1:0]        cur_pc,
	input  logic [LANES-1:0]          cur_mask,
	input  logic [SP_W-1:0]           cur_sp,
	input  logic [PC_BITS-1:0]        branch_pc,
	input  logic [PC_BITS-1:0]        target,
	input  logic [LANES-1:0]          taken_mask,
	input  logic                      reconv_valid,
	input  logic [PC_BITS-1:0]        reconv_pc,
	input  logic [PC_BITS-1:0]        top_pc,
	input  logic [LANES-1:0]          top_mask,
	output sds_pkg::sds_ctrl_t        ctrl,
	output logic [PC_BITS-1:0]        new_pc,
	output logic [LANES-1:0]          new_mask,
	output logic [SP_W-1:0]           new_sp,
	output logic [PC_BITS-1:0]        push0_pc,
	output logic [LANES-1:0]          push0_mask,
	output logic [PC_BITS-1:0]        push1_pc,
	output logic [LANES-1:0]          push1_mask
);
	logic [LANES-1:0]   tk;
	logic [LANES-1:0]   ntk;
	logic [PC_BITS-1:0] fall;
	logic [SP_W:0]      sp_plus2;

	assign tk         = taken_mask & cur_mask;
	assign ntk        = cur_mask & ~tk;
	assign fall       = branch_pc + PC_BITS'(1);
	assign sp_plus2   = {1'b0, cur_sp} + (SP_W+1)'(2);
	assign push0_pc   = reconv_pc;
	assign push0_mask = cur_mask;
	assign push1_pc   = fall;
	assign push1_mask = ntk;

	always_comb begin
		ctrl     = '0;
		new_pc   = cur_pc;
		new_mask = cur_mask;
		new_sp   = cur_sp;
		case (sds_pkg::sds_cmd_t'(cmd))
			sds_pkg::CMD_LAUNCH: begin
				ctrl.launch = 1'b1;
				new_pc      = '0;
				new_mask    = '1;
				new_sp      = '0;
			end
			sds_pkg::CMD_BRANCH: begin
				if (tk == '0 || ntk == '0) begin
					new_pc = (tk != '0) ? target : fall;
				end else if (!reconv_valid) begin
					ctrl.err = 1'b1;
				end else if (target == reconv_pc) begin
					if (cur_sp >= SP_W'(STACK_DEPTH)) begin
						ctrl.err = 1'b1;
					end else begin
						ctrl.push_one = 1'b1;
						new_sp        = cur_sp + SP_W'(1);
						new_mask      = ntk;
						new_pc        = fall;
					end
				end else begin
					if (sp_plus2 > (SP_W+1)'(STACK_DEPTH)) begin
						ctrl.err = 1'b1;
					end else begin
						ctrl.push_two = 1'b1;
						new_sp        = sp_plus2[SP_W-1:0];
						new_mask      = tk;
						new_pc        = target;
					end
				end
			end
			sds_pkg::CMD_JOIN: begin
				if (cur_sp != '0) begin
					new_pc   = top_pc;
					new_mask = top_mask;
					new_sp   = cur_sp - SP_W'(1);
				end else begin
					new_pc = target;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

### hw/rtl/sds_stack.sv
// Per-warp divergence stack entries: one- or two-entry push and top-of-stack read.
module sds_stack #(
	parameter int NUM_WARPS   = 4,
	parameter int LANES       = 8,
	parameter int STACK_DEPTH = 4,
	parameter int PC_BITS     = 16,
	localparam int WARP_W     = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1,
	localparam int SP_W       = $clog2(STACK_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               en,
	input  sds_pkg::sds_ctrl_t ctrl,
	input  logic [WARP_W-1:0]  warp,
	input  logic [SP_W-1:0]    sp,
	input  logic [PC_BITS-1:0] push0_pc,
	input  logic [LANES-1:0]   push0_mask,
	input  logic [PC_BITS-1:0] push1_pc,
	input  logic [LANES-1:0]   push1_mask,
	output logic [PC_BITS-1:0] top_pc,
	output logic [LANES-1:0]   top_mask
);
	localparam int SLOT_W = $clog2(STACK_DEPTH);

	logic [PC_BITS-1:0] ent_pc_q   [NUM_WARPS][STACK_DEPTH];
	logic [LANES-1:0]   ent_mask_q [NUM_WARPS][STACK_DEPTH];
	logic [SP_W-1:0]    sp_dec;
	logic [SLOT_W-1:0]  slot0;
	logic [SLOT_W-1:0]  slot1;
	logic [SLOT_W-1:0]  slot_top;

	assign sp_dec   = sp - SP_W'(1);
	assign slot0    = sp[SLOT_W-1:0];
	assign slot1    = slot0 + SLOT_W'(1);
	assign slot_top = sp_dec[SLOT_W-1:0];
	assign top_pc   = ent_pc_q[warp][slot_top];
	assign top_mask = ent_mask_q[warp][slot_top];

	always_ff @(posedge clk) begin
		if (en && (ctrl.push_one || ctrl.push_two)) begin
			ent_pc_q[warp][slot0]   <= push0_pc;
			ent_mask_q[warp][slot0] <= push0_mask;
		end
		if (en && ctrl.push_two) begin
			ent_pc_q[warp][slot1]   <= push1_pc;
			ent_mask_q[warp][slot1] <= push1_mask;
		end
	end
endmodule

### hw/rtl/simt_divergence_stack.sv
// Top level of the SIMT divergence stack: input register, warp state, result register.
//
// Tracks pc, active lane mask and a reconvergence stack for each warp. Every
// command (launch, branch resolution, join) yields exactly one result. One
// transaction is accepted per cycle while the input register is empty or can
// drain; each is held in the input register, then the result register, around
// the combinational resolve logic. The warp state is written as an item moves
// into the result register, so back-to-back items on the same warp see each
// other's updates. A stalled result holds the pipeline; an input is still
// taken while the input register drains into a free result register.
module simt_divergence_stack #(
	parameter int NUM_WARPS   = 4,
	parameter int LANES       = 8,
	parameter int STACK_DEPTH = 4,
	parameter int PC_BITS     = 16
) (
	input logic      clk,
	input logic      arst_n,
	sds_in_if.sink   in_ch,
	sds_out_if.source out_ch
);
	localparam int WARP_W = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1;
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);

	logic                      vld_s1;
	logic [sds_pkg::CMD_W-1:0] cmd_s1;
	logic [WARP_W-1:0]         warp_s1;
	logic [PC_BITS-1:0]        bpc_s1;
	logic [PC_BITS-1:0]        tgt_s1;
	logic [LANES-1:0]          taken_s1;
	logic                      rvld_s1;
	logic [PC_BITS-1:0]        rpc_s1;

	logic [PC_BITS-1:0] warp_pc_q   [NUM_WARPS];
	logic [LANES-1:0]   warp_mask_q [NUM_WARPS];
	logic [SP_W-1:0]    warp_sp_q   [NUM_WARPS];

	logic               res_vld_q;
	logic [WARP_W-1:0]  res_warp_q;
	logic [PC_BITS-1:0] res_pc_q;
	logic [LANES-1:0]   res_mask_q;
	logic [SP_W-1:0]    res_sp_q;
	logic               res_err_q;

	logic               advance;
	logic               fire;
	logic               in_range;
	logic [PC_BITS-1:0] cur_pc;
	logic [LANES-1:0]   cur_mask;
	logic [SP_W-1:0]    cur_sp;
	logic [PC_BITS-1:0] top_pc;
	logic [LANES-1:0]   top_mask;
	sds_pkg::sds_ctrl_t ctrl;
	logic [PC_BITS-1:0] new_pc;
	logic [LANES-1:0]   new_mask;
	logic [SP_W-1:0]    new_sp;
	logic [PC_BITS-1:0] push0_pc;
	logic [LANES-1:0]   push0_mask;
	logic [PC_BITS-1:0] push1_pc;
	logic [LANES-1:0]   push1_mask;

	assign advance     = !res_vld_q || out_ch.ready;
	assign fire        = vld_s1 && advance;
	assign in_ch.ready = !vld_s1 || advance;
	assign in_range    = (int'(warp_s1) < NUM_WARPS);
	assign cur_pc      = warp_pc_q[warp_s1];
	assign cur_mask    = warp_mask_q[warp_s1];
	assign cur_sp      = warp_sp_q[warp_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			cmd_s1   <= in_ch.cmd;
			warp_s1  <= in_ch.warp;
			bpc_s1   <= in_ch.branch_pc;
			tgt_s1   <= in_ch.target;
			taken_s1 <= in_ch.taken_mask;
			rvld_s1  <= in_ch.reconv_valid;
			rpc_s1   <= in_ch.reconv_pc;
		end
	end

	sds_resolve #(
		.LANES       (LANES),
		.STACK_DEPTH (STACK_DEPTH),
		.PC_BITS     (PC_BITS)
	) u_resolve (
		.cmd          (cmd_s1),
		.cur_pc       (cur_pc),
		.cur_mask     (cur_mask),
		.cur_sp       (cur_sp),
		.branch_pc    (bpc_s1),
		.target       (tgt_s1),
		.taken_mask   (taken_s1),
		.reconv_valid (rvld_s1),
		.reconv_pc    (rpc_s1),
		.top_pc       (top_pc),
		.top_mask     (top_mask),
		.ctrl         (ctrl),
		.new_pc       (new_pc),
		.new_mask     (new_mask),
		.new_sp       (new_sp),
		.push0_pc     (push0_pc),
		.push0_mask   (push0_mask),
		.push1_pc     (push1_pc),
		.push1_mask   (push1_mask)
	);

	sds_stack #(
		.NUM_WARPS   (NUM_WARPS),
		.LANES       (LANES),
		.STACK_DEPTH (STACK_DEPTH),
		.PC_BITS     (PC_BITS)
	) u_stack (
		.clk        (clk),
		.en         (fire && in_range),
		.ctrl       (ctrl),
		.warp       (warp_s1),
		.sp         (cur_sp),
		.push0_pc   (push0_pc),
		.push0_mask (push0_mask),
		.push1_pc   (push1_pc),
		.push1_mask (push1_mask),
		.top_pc     (top_pc),
		.top_mask   (top_mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < NUM_WARPS; w++) begin
				warp_pc_q[w]   <= '0;
				warp_mask_q[w] <= '1;
				warp_sp_q[w]   <= '0;
			end
		end else if (fire && in_range) begin
			if (ctrl.launch) begin
				for (int w = 0; w < NUM_WARPS; w++) begin
					warp_pc_q[w]   <= '0;
					warp_mask_q[w] <= '1;
					warp_sp_q[w]   <= '0;
				end
			end else begin
				warp_pc_q[warp_s1]   <= new_pc;
				warp_mask_q[warp_s1] <= new_mask;
				warp_sp_q[warp_s1]   <= new_sp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_warp_q <= warp_s1;
			res_pc_q   <= in_range ? new_pc : '0;
			res_mask_q <= in_range ? new_mask : '0;
			res_sp_q   <= in_range ? new_sp : '0;
			res_err_q  <= in_range ? ctrl.err : 1'b1;
		end
	end

	assign out_ch.valid       = res_vld_q;
	assign out_ch.warp_out    = res_warp_q;
	assign out_ch.next_pc     = res_pc_q;
	assign out_ch.active_mask = res_mask_q;
	assign out_ch.stack_depth = res_sp_q;
	assign out_ch.error       = res_err_q;
endmodule

### hw/rtl/sds_checker.sv
// Port-level checker of the SIMT divergence stack, bound to the top level.
`include "simt_divergence_stack_macros.svh"

module sds_checker #(
	parameter int NUM_WARPS   = 4,
	parameter int LANES       = 8,
	parameter int STACK_DEPTH = 4,
	parameter int PC_BITS     = 16,
	localparam int WARP_W     = (NUM_WARPS > 1) ? $clog2(NUM_WARPS) : 1,
	localparam int SP_W       = $clog2(STACK_DEPTH + 1)
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [WARP_W-1:0]  warp_out,
	input logic [PC_BITS-1:0] next_pc,
	input logic [LANES-1:0]   active_mask,
	input logic [SP_W-1:0]    stack_depth,
	input logic               error
);
	localparam int PAYLOAD_W = WARP_W + PC_BITS + LANES + SP_W + 1;

	logic [PAYLOAD_W-1:0] out_payload;

	assign out_payload = {warp_out, next_pc, active_mask, stack_depth, error};

	`SDS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_payload))
	`SDS_ASSERT_IMP(a_ready_when_empty, !out_valid, in_ready)
	`SDS_ASSERT_IMP(a_depth_bound, out_valid, stack_depth <= SP_W'(STACK_DEPTH))
	`SDS_ASSERT_IMP(a_mask_nonzero, out_valid && !error, active_mask != '0)
endmodule

bind simt_divergence_stack sds_checker #(
	.NUM_WARPS   (NUM_WARPS),
	.LANES       (LANES),
	.STACK_DEPTH (STACK_DEPTH),
	.PC_BITS     (PC_BITS)
) u_sds_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.warp_out    (out_ch.warp_out),
	.next_pc     (out_ch.next_pc),
	.active_mask (out_ch.active_mask),
	.stack_depth (out_ch.stack_depth),
	.error       (out_ch.error)
);
